[sv/ptw_pkg.sv]
package ptw_pkg;

	localparam int VA_W   = 48;
	localparam int PA_W   = 52;
	localparam int WORD_W = 64;

	// action codes on the input channel
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_WORD  = 1'b1;

	// result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// page sizes
	localparam logic [1:0] PS_4K = 2'd0;
	localparam logic [1:0] PS_2M = 2'd1;
	localparam logic [1:0] PS_1G = 2'd2;

	// table levels, top first
	localparam logic [1:0] LVL_PML4 = 2'd3;
	localparam logic [1:0] LVL_PDPT = 2'd2;
	localparam logic [1:0] LVL_PD   = 2'd1;
	localparam logic [1:0] LVL_PT   = 2'd0;

	localparam int PRESENT_BIT = 0;
	localparam int PS_BIT      = 7;

	typedef struct packed {
		logic              start;
		logic [VA_W-1:0]   va;
		logic [WORD_W-1:0] word;
	} item_t;

	typedef struct packed {
		logic            kind;
		logic [PA_W-1:0] addr;
		logic            fault;
		logic [1:0]      size;
	} result_t;

endpackage

[sv/ptw_front.sv]
module ptw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [ptw_pkg::VA_W-1:0]      virtual_address,
	input  logic [ptw_pkg::WORD_W-1:0]    table_word,
	output logic                          push_valid,
	output ptw_pkg::item_t                push_item,
	input  logic                          push_ready
);

	logic           valid_s1;
	ptw_pkg::item_t item_s1;
	logic           accept;

	assign in_stall = valid_s1 && !push_ready;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify: start requests versus returned table words
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.start <= (action == ptw_pkg::ACT_START);
			item_s1.va    <= virtual_address;
			item_s1.word  <= table_word;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

[sv/ptw_queue.sv]
module ptw_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  ptw_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output ptw_pkg::item_t pop_item,
	input  logic           pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ptw_pkg::item_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[sv/ptw_back.sv]
module ptw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ptw_pkg::PA_W-1:0]   root_base,
	input  logic                       pop_valid,
	input  ptw_pkg::item_t             pop_item,
	output logic                       pop_ready,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ptw_pkg::result_t           result
);

	logic                       busy_q;
	logic [1:0]                 level_q;
	logic [ptw_pkg::VA_W-1:0]   va_q;
	logic                       out_valid_q;
	ptw_pkg::result_t           result_q;

	logic                       pop;
	logic                       emit;
	ptw_pkg::result_t           res_next;
	logic                       busy_next;
	logic [1:0]                 level_next;
	logic                       present;
	logic                       ps_bit;
	logic [1:0]                 level_dn;
	logic [8:0]                 next_index;

	assign pop_ready = !out_valid_q || !out_stall;
	assign pop       = pop_valid && pop_ready;
	assign present   = pop_item.word[ptw_pkg::PRESENT_BIT];
	assign ps_bit    = pop_item.word[ptw_pkg::PS_BIT];
	assign level_dn  = level_q - 2'd1;

	// index of the entry in the next table down
	always_comb begin
		case (level_dn)
			ptw_pkg::LVL_PML4: next_index = va_q[47:39];
			ptw_pkg::LVL_PDPT: next_index = va_q[38:30];
			ptw_pkg::LVL_PD:   next_index = va_q[29:21];
			default:           next_index = va_q[20:12];
		endcase
	end

	always_comb begin
		emit       = 1'b1;
		busy_next  = busy_q;
		level_next = level_q;
		res_next   = '{kind: ptw_pkg::KIND_DONE, addr: '0, fault: 1'b0, size: ptw_pkg::PS_4K};
		if (pop_item.start) begin
			busy_next     = 1'b1;
			level_next    = ptw_pkg::LVL_PML4;
			res_next.kind = ptw_pkg::KIND_READ;
			res_next.addr = {root_base[51:12], pop_item.va[47:39], 3'b000};
		end else if (!busy_q) begin
			emit = 1'b0;
		end else if (!present) begin
			busy_next      = 1'b0;
			level_next     = ptw_pkg::LVL_PT;
			res_next.fault = 1'b1;
		end else if (level_q == ptw_pkg::LVL_PDPT && ps_bit) begin
			busy_next     = 1'b0;
			level_next    = ptw_pkg::LVL_PT;
			res_next.addr = {pop_item.word[51:30], va_q[29:0]};
			res_next.size = ptw_pkg::PS_1G;
		end else if (level_q == ptw_pkg::LVL_PD && ps_bit) begin
			busy_next     = 1'b0;
			level_next    = ptw_pkg::LVL_PT;
			res_next.addr = {pop_item.word[51:21], va_q[20:0]};
			res_next.size = ptw_pkg::PS_2M;
		end else if (level_q == ptw_pkg::LVL_PT) begin
			busy_next     = 1'b0;
			res_next.addr = {pop_item.word[51:12], va_q[11:0]};
		end else begin
			level_next    = level_dn;
			res_next.kind = ptw_pkg::KIND_READ;
			res_next.addr = {pop_item.word[51:12], next_index, 3'b000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= ptw_pkg::LVL_PT;
			va_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= busy_next;
				level_q <= level_next;
				if (pop_item.start) begin
					va_q <= pop_item.va;
				end
			end
			if (pop_ready) begin
				out_valid_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

[sv/four_level_page_table_walker.sv]
// Each item is registered in the input stage, the queue and the output register before its
// result is valid.
// Throughput: one item per cycle while out_stall is low; each popped item steps the walk.
// A held result stalls the back end; queue and input stage then fill and in_stall rises.
// Table words that arrive while no walk is active produce no result.
// Reset (arst_n low, async): walk idle, queue and output empty, root_table_base cleared.
module four_level_page_table_walker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [51:0]                cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [47:0]                virtual_address,
	input  logic [63:0]                table_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       kind,
	output logic [51:0]                phys_address,
	output logic                       fault,
	output logic [1:0]                 map_size
);

	logic [51:0]      root_table_base_q;
	logic             push_valid;
	logic             push_ready;
	ptw_pkg::item_t   push_item;
	logic             pop_valid;
	logic             pop_ready;
	ptw_pkg::item_t   pop_item;
	ptw_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_table_base_q <= '0;
		end else if (cfg_we) begin
			root_table_base_q <= cfg_wdata;
		end
	end

	ptw_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.virtual_address (virtual_address),
		.table_word      (table_word),
		.push_valid      (push_valid),
		.push_item       (push_item),
		.push_ready      (push_ready)
	);

	ptw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	ptw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.root_base (root_table_base_q),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign kind         = result.kind;
	assign phys_address = result.addr;
	assign fault        = result.fault;
	assign map_size     = result.size;

`ifndef NO_ASSERTIONS
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> kind == ptw_pkg::KIND_DONE && phys_address == '0
			&& map_size == ptw_pkg::PS_4K)
		else $error("fault result carries address or size");

	a_read_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ptw_pkg::KIND_READ |-> !fault && map_size == ptw_pkg::PS_4K
			&& phys_address[2:0] == 3'b000)
		else $error("read request malformed");

	a_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> map_size != 2'd3)
		else $error("illegal page size code");
`endif

endmodule

[bench/tb_four_level_page_table_walker.sv]
module tb_four_level_page_table_walker;
	import ptw_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_PHASE   = 3;
	localparam int PHASE_ITEMS  = 222;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [51:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = ACT_START;
	logic [47:0] virtual_address = '0;
	logic [63:0] table_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [51:0] phys_address;
	logic        fault;
	logic [1:0]  map_size;

	four_level_page_table_walker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.virtual_address(virtual_address),
		.table_word(table_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.phys_address(phys_address),
		.fault(fault),
		.map_size(map_size)
	);

	always #2 clk = ~clk;

	// walker state as the bench sees it
	logic [51:0] root_base = '0;
	logic        walk_busy = 1'b0;
	logic [1:0]  walk_lvl = LVL_PT;
	logic [47:0] walk_va = '0;

	result_t expected_q[$];
	result_t next_result;
	int      errors = 0;
	int      n_sent = 0;
	int      cycle_cnt = 0;
	int      phase_no = 0;
	bit      tx_gaps = 1'b1;
	bit      rx_idle = 1'b1;
	bit      hold_done = 1'b0;
	int      stall_left = 0;
	int      rx_roll;

	typedef struct {
		logic        act;
		logic [47:0] va;
		logic [63:0] word;
		bit          typed;
		result_t     res;
	} row_t;

	row_t plan[$];

	function automatic logic [51:0] entry_addr(logic [51:0] base, logic [1:0] lvl);
		logic [8:0] idx;
		idx = 9'(walk_va >> (12 + 9 * lvl));
		return {base[51:12], idx, 3'b000};
	endfunction

	function automatic logic [51:0] page_addr(logic [63:0] w, int sh);
		logic [51:0] low;
		low = (52'd1 << sh) - 52'd1;
		return (w[51:0] & ~low) | ({4'b0, walk_va} & low);
	endfunction

	// advances the walk by one transfer; returns 1 when a result is due
	function automatic bit walk_predict(logic act, logic [47:0] va, logic [63:0] w,
			output result_t r);
		r = '0;
		if (act == ACT_START) begin
			walk_va = va;
			walk_lvl = LVL_PML4;
			walk_busy = 1'b1;
			r.kind = KIND_READ;
			r.addr = entry_addr(root_base, LVL_PML4);
			return 1'b1;
		end
		if (!walk_busy)
			return 1'b0;
		walk_busy = 1'b0;
		r.kind = KIND_DONE;
		if (!w[PRESENT_BIT]) begin
			r.fault = 1'b1;
			walk_lvl = LVL_PT;
		end else if (w[PS_BIT] && walk_lvl == LVL_PDPT) begin
			r.addr = page_addr(w, 30);
			r.size = PS_1G;
			walk_lvl = LVL_PT;
		end else if (w[PS_BIT] && walk_lvl == LVL_PD) begin
			r.addr = page_addr(w, 21);
			r.size = PS_2M;
			walk_lvl = LVL_PT;
		end else if (walk_lvl == LVL_PT) begin
			r.addr = page_addr(w, 12);
			r.size = PS_4K;
		end else begin
			walk_busy = 1'b1;
			walk_lvl = walk_lvl - 2'd1;
			r.kind = KIND_READ;
			r.addr = entry_addr(w[51:0], walk_lvl);
		end
		return 1'b1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!tx_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [47:0] rand_va();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {16'($urandom), $urandom};
	endfunction

	task automatic send(logic a, logic [47:0] va, logic [63:0] w, bit typed = 1'b0,
			result_t typed_res = '0);
		result_t r;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		virtual_address <= va;
		table_word <= w;
		do @(posedge clk); while (in_stall);
		if (walk_predict(a, va, w, r))
			expected_q.push_back(typed ? typed_res : r);
		n_sent++;
	endtask

	task automatic plan_row(logic a, logic [47:0] va, logic [63:0] w, bit typed = 1'b0,
			result_t res = '0);
		row_t row;
		row.act = a;
		row.va = va;
		row.word = w;
		row.typed = typed;
		row.res = res;
		plan.push_back(row);
	endtask

	// walks mostly run to the end; a few are cut short by the next start
	task automatic random_walk();
		logic [63:0] w;
		int r;
		send(ACT_START, rand_va(), {$urandom, $urandom});
		while (walk_busy) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				return;
			w = {$urandom, $urandom};
			w[PRESENT_BIT] = (r >= 10);
			if (walk_lvl == LVL_PDPT || walk_lvl == LVL_PD)
				w[PS_BIT] = ($urandom_range(0, 3) == 0);
			send(ACT_WORD, rand_va(), w);
		end
	endtask

	task automatic settle_and_write(logic [51:0] v);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		// stray words may still be in flight with no result to wait on
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		root_base = v;
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transfer: kind %0d addr %h fault %0d size %0d",
					$time, kind, phys_address, fault, map_size);
				errors++;
			end else begin
				next_result = expected_q.pop_front();
				check_field("kind", 64'(next_result.kind), 64'(kind));
				check_field("phys_address", 64'(next_result.addr), 64'(phys_address));
				check_field("fault", 64'(next_result.fault), 64'(fault));
				check_field("map_size", 64'(next_result.size), 64'(map_size));
			end
		end
	end

	// result side back-pressure; one long hold-off in the hold phase
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (phase_no == HOLD_PHASE && !hold_done) begin
			hold_done = 1'b1;
			stall_left = 150;
			out_stall <= 1'b1;
		end else if (!rx_idle) begin
			out_stall <= 1'b0;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [51:0] bases[6];
		bases[0] = 52'hF_FFFF_FFFF_FFFF;
		bases[1] = {20'($urandom), $urandom};
		bases[2] = 52'h0_0000_0000_0FFF;
		bases[3] = 52'h0;
		bases[4] = {20'($urandom), $urandom};
		bases[5] = 52'hA_5A5A_5A5A_5000;

		// root base is zero out of reset
		plan_row(ACT_START, 48'h0, '1, 1'b1, {KIND_READ, 52'h0, 1'b0, PS_4K});
		plan_row(ACT_WORD, '1, 64'h0, 1'b1, {KIND_DONE, 52'h0, 1'b1, PS_4K});
		plan_row(ACT_WORD, '1, '1);                   // no walk: dropped
		plan_row(ACT_START, '1, 64'h0, 1'b1, {KIND_READ, 52'hFF8, 1'b0, PS_4K});
		plan_row(ACT_WORD, '0, '1);                   // page-size bit ignored at top
		plan_row(ACT_WORD, '0, '1);                   // 1 GiB page
		plan_row(ACT_START, 48'h0000_4020_1000, '0);
		plan_row(ACT_WORD, '0, 64'h8000_0000_0000_1001);
		plan_row(ACT_WORD, '0, 64'h0000_0000_0002_3003);
		plan_row(ACT_WORD, '0, 64'h0000_0000_4060_0081); // 2 MiB page
		plan_row(ACT_START, 48'h8000_0000_0000, '1);
		plan_row(ACT_WORD, '0, 64'h0000_0000_0000_5083);
		plan_row(ACT_WORD, '0, 64'h7FF0_0000_0000_6001);
		plan_row(ACT_WORD, '0, 64'h0000_0000_0000_7003);
		plan_row(ACT_WORD, '0, 64'hFFF0_0000_0000_8081); // page-size bit at last level
		plan_row(ACT_START, 48'h1234_5678_9ABC, '0);
		plan_row(ACT_START, 48'h7FFF_FFFF_F000, '0);   // abandons the running walk
		plan_row(ACT_WORD, '0, 64'h000F_FFFF_FFFF_F001);
		plan_row(ACT_WORD, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
			{KIND_DONE, 52'h0, 1'b1, PS_4K});
		plan_row(ACT_WORD, '0, 64'h1);
		plan_row(ACT_START, 48'h0000_0000_0FFF, '0);
		plan_row(ACT_WORD, '1, 64'h000F_FFFF_C000_0081);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send(plan[i].act, plan[i].va, plan[i].word, plan[i].typed, plan[i].res);

		for (int p = 1; p <= 6; p++) begin
			settle_and_write(bases[p - 1]);
			tx_gaps = (p != 1 && p != HOLD_PHASE);
			rx_idle = (p != 1);
			phase_no = p;
			while (n_sent < 25 + p * PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					send(ACT_WORD, rand_va(), {$urandom, $urandom});
				else
					random_walk();
			end
		end

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[four_level_page_table_walker.f]
sv/ptw_pkg.sv
sv/ptw_front.sv
sv/ptw_queue.sv
sv/ptw_back.sv
sv/four_level_page_table_walker.sv
bench/tb_four_level_page_table_walker.sv
